>>> rtl/achr_pkg.sv
// achr_pkg: shared widths, register indexes, reset values and structs for the
// autocorrelation heart-rate block. No dependencies.
package achr_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int HR_W       = 16;
	localparam int STEP_W     = 8;
	localparam int LAG_W      = 7;
	localparam int LAGC_W     = LAG_W + 1;
	localparam int RATE_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int DEF_WINDOW_LENGTH  = 128;
	localparam int DEF_HISTORY_LENGTH = 8;
	localparam int DEF_MEDIAN_SPAN    = 4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ANALYSIS_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LAG           = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LAG           = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_CONSTANT     = 2'd3;

	// configuration reset values
	localparam logic [STEP_W-1:0] RST_ANALYSIS_INTERVAL = 8'd64;
	localparam logic [LAG_W-1:0]  RST_MIN_LAG           = 7'd8;
	localparam logic [LAG_W-1:0]  RST_MAX_LAG           = 7'd40;
	localparam logic [RATE_W-1:0] RST_RATE_CONSTANT     = 16'd15000;

	typedef struct packed {
		logic [STEP_W-1:0] analysis_interval;
		logic [LAG_W-1:0]  min_lag;
		logic [LAG_W-1:0]  max_lag;
		logic [RATE_W-1:0] rate_constant;
	} cfg_t;

	// head of the front-to-back queue
	typedef struct packed {
		logic valid;
		logic trig;
	} desc_t;

	// back-to-front control
	typedef struct packed {
		logic pop;
		logic analysis_done;
	} back_ctl_t;

	typedef struct packed {
		logic [HR_W-1:0] hr;
		logic            upd;
	} result_t;

endpackage

>>> rtl/achr_ram.sv
// achr_ram: generic RAM, one write port and two registered read ports.
// No dependencies.
module achr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

>>> rtl/achr_front.sv
// achr_front: accepts samples, writes the window, holds configuration and
// marks which samples start an analysis. Depends on achr_pkg.
module achr_front #(
	parameter int WINDOW_LENGTH = achr_pkg::DEF_WINDOW_LENGTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic [achr_pkg::SAMPLE_W-1:0]        filtered_sample,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [achr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [achr_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                 ram_we,
	output logic [$clog2(WINDOW_LENGTH)-1:0]     ram_waddr,
	output logic [achr_pkg::SAMPLE_W-1:0]        ram_wdata,
	output logic [$clog2(WINDOW_LENGTH):0]       fill,
	output achr_pkg::cfg_t                       cfg,
	output achr_pkg::desc_t                      desc,
	input  achr_pkg::back_ctl_t                  ctl
);
	import achr_pkg::*;

	localparam int AW = $clog2(WINDOW_LENGTH);

	logic [AW-1:0]     wr_ptr_q;
	logic [AW:0]       fill_q;
	logic [STEP_W-1:0] since_q;
	logic [STEP_W-1:0] since_inc;
	logic              hold_q;
	logic [1:0]        dcnt_q;
	logic              d0_q;
	logic              d1_q;
	cfg_t              cfg_q;
	logic              accept;
	logic              trig;

	// input transfer and analysis trigger
	assign accept    = push & ~full;
	assign full      = hold_q | (dcnt_q == 2'd2);
	assign since_inc = since_q + STEP_W'(1);
	assign trig      = (since_inc >= cfg_q.analysis_interval);
	assign cfg_ready = 1'b1;

	assign ram_we    = accept;
	assign ram_waddr = wr_ptr_q;
	assign ram_wdata = filtered_sample;
	assign fill      = fill_q;
	assign cfg       = cfg_q;
	assign desc.valid = (dcnt_q != 2'd0);
	assign desc.trig  = d0_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.analysis_interval <= RST_ANALYSIS_INTERVAL;
			cfg_q.min_lag           <= RST_MIN_LAG;
			cfg_q.max_lag           <= RST_MAX_LAG;
			cfg_q.rate_constant     <= RST_RATE_CONSTANT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ANALYSIS_INTERVAL: cfg_q.analysis_interval <= cfg_data[STEP_W-1:0];
				REG_MIN_LAG:           cfg_q.min_lag           <= cfg_data[LAG_W-1:0];
				REG_MAX_LAG:           cfg_q.max_lag           <= cfg_data[LAG_W-1:0];
				REG_RATE_CONSTANT:     cfg_q.rate_constant     <= cfg_data[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	// window pointer, fill count, step counter and hold during analysis
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			fill_q   <= '0;
			since_q  <= '0;
			hold_q   <= 1'b0;
		end else begin
			if (accept) begin
				wr_ptr_q <= (wr_ptr_q == AW'(WINDOW_LENGTH - 1)) ? '0 : wr_ptr_q + AW'(1);
				if (fill_q != (AW+1)'(WINDOW_LENGTH)) begin
					fill_q <= fill_q + (AW+1)'(1);
				end
				since_q <= trig ? '0 : since_inc;
			end
			if (accept && trig) begin
				hold_q <= 1'b1;
			end else if (ctl.analysis_done) begin
				hold_q <= 1'b0;
			end
		end
	end

	// two-entry queue to the back part
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= 2'd0;
			d0_q   <= 1'b0;
			d1_q   <= 1'b0;
		end else begin
			case ({accept, ctl.pop})
				2'b10: begin
					if (dcnt_q == 2'd0) begin
						d0_q <= trig;
					end else begin
						d1_q <= trig;
					end
					dcnt_q <= dcnt_q + 2'd1;
				end
				2'b01: begin
					d0_q   <= d1_q;
					dcnt_q <= dcnt_q - 2'd1;
				end
				2'b11: begin
					if (dcnt_q == 2'd1) begin
						d0_q <= trig;
					end else begin
						d0_q <= d1_q;
						d1_q <= trig;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/achr_corr.sv
// achr_corr: circular autocorrelation at one lag, one product per cycle
// through a two-port window read. Depends on achr_pkg.
module achr_corr #(
	parameter int WINDOW_LENGTH = achr_pkg::DEF_WINDOW_LENGTH
) (
	input  logic                                                    clk,
	input  logic                                                    arst_n,
	input  logic                                                    start,
	input  logic [$clog2(WINDOW_LENGTH)-1:0]                        lag_idx,
	input  logic [$clog2(WINDOW_LENGTH):0]                          fill,
	output logic [$clog2(WINDOW_LENGTH)-1:0]                        raddr_a,
	output logic [$clog2(WINDOW_LENGTH)-1:0]                        raddr_b,
	input  logic [achr_pkg::SAMPLE_W-1:0]                           rdata_a,
	input  logic [achr_pkg::SAMPLE_W-1:0]                           rdata_b,
	output logic                                                    done,
	output logic signed [2*achr_pkg::SAMPLE_W+$clog2(WINDOW_LENGTH):0] result
);
	import achr_pkg::*;

	localparam int AW     = $clog2(WINDOW_LENGTH);
	localparam int PROD_W = 2 * SAMPLE_W;
	localparam int ACC_W  = PROD_W + AW + 1;

	logic                       busy_q;
	logic [AW-1:0]              i_q;
	logic [AW-1:0]              j_q;
	logic                       iss_s1;
	logic                       last_s1;
	logic                       va_s1;
	logic                       vb_s1;
	logic                       v_s2;
	logic                       last_s2;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       done_q;
	logic signed [SAMPLE_W-1:0] a_val;
	logic signed [SAMPLE_W-1:0] b_val;
	logic                       last_iss;

	assign last_iss = (i_q == AW'(WINDOW_LENGTH - 1));
	assign raddr_a  = i_q;
	assign raddr_b  = j_q;

	// entries never written read as zero
	assign a_val = va_s1 ? $signed(rdata_a) : '0;
	assign b_val = vb_s1 ? $signed(rdata_b) : '0;

	assign done   = done_q;
	assign result = acc_q;

	// address sweep over the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q    <= '0;
			j_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			i_q    <= '0;
			j_q    <= lag_idx;
		end else if (busy_q) begin
			i_q <= i_q + AW'(1);
			j_q <= (j_q == AW'(WINDOW_LENGTH - 1)) ? '0 : j_q + AW'(1);
			if (last_iss) begin
				busy_q <= 1'b0;
			end
		end
	end

	// read, multiply and accumulate stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1  <= 1'b0;
			last_s1 <= 1'b0;
			va_s1   <= 1'b0;
			vb_s1   <= 1'b0;
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
			prod_s2 <= '0;
			acc_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			iss_s1  <= busy_q;
			last_s1 <= busy_q & last_iss;
			va_s1   <= ({1'b0, i_q} < fill);
			vb_s1   <= ({1'b0, j_q} < fill);
			v_s2    <= iss_s1;
			last_s2 <= last_s1;
			prod_s2 <= PROD_W'(a_val * b_val);
			if (start) begin
				acc_q <= '0;
			end else if (v_s2) begin
				acc_q <= acc_q + {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
			end
			done_q <= v_s2 & last_s2;
		end
	end

endmodule

>>> rtl/achr_div.sv
// achr_div: restoring divider, one quotient bit per cycle.
// No dependencies.
module achr_div #(
	parameter int NUM_W = 19,
	parameter int DEN_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             ge;

	// shift in the next dividend bit and try the subtract
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign ge    = (trial >= {1'b0, den_q});
	assign done  = done_q;
	assign quot  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				quo_q <= num;
				den_q <= den;
				rem_q <= '0;
				cnt_q <= CNT_W'(NUM_W);
				run_q <= 1'b1;
			end else if (run_q) begin
				quo_q <= {quo_q[NUM_W-2:0], ge};
				rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

>>> rtl/achr_back.sv
// achr_back: peak search sequencer, rate history with sort and mean, and the
// result queue. Depends on achr_pkg; drives achr_corr and achr_div.
module achr_back #(
	parameter int WINDOW_LENGTH  = achr_pkg::DEF_WINDOW_LENGTH,
	parameter int HISTORY_LENGTH = achr_pkg::DEF_HISTORY_LENGTH,
	parameter int MEDIAN_SPAN    = achr_pkg::DEF_MEDIAN_SPAN
) (
	input  logic                                                       clk,
	input  logic                                                       arst_n,
	input  achr_pkg::cfg_t                                             cfg,
	input  achr_pkg::desc_t                                            desc,
	output achr_pkg::back_ctl_t                                        ctl,
	output logic                                                       corr_start,
	output logic [$clog2(WINDOW_LENGTH)-1:0]                           corr_k,
	input  logic                                                       corr_done,
	input  logic signed [2*achr_pkg::SAMPLE_W+$clog2(WINDOW_LENGTH):0] corr_result,
	output logic                                                       div_start,
	output logic [achr_pkg::HR_W+$clog2(HISTORY_LENGTH+1)-1:0]         div_num,
	output logic [achr_pkg::LAGC_W-1:0]                                div_den,
	input  logic                                                       div_done,
	input  logic [achr_pkg::HR_W+$clog2(HISTORY_LENGTH+1)-1:0]         div_quot,
	output logic                                                       empty,
	input  logic                                                       pop,
	output logic [achr_pkg::HR_W-1:0]                                  heart_rate_x10,
	output logic                                                       estimate_updated
);
	import achr_pkg::*;

	localparam int AW    = $clog2(WINDOW_LENGTH);
	localparam int ACC_W = 2 * SAMPLE_W + AW + 1;
	localparam int CW    = $clog2(HISTORY_LENGTH + 1);
	localparam int NUM_W = HR_W + CW;
	localparam int HIW   = $clog2(HISTORY_LENGTH);
	localparam int MID_FIRST = (MEDIAN_SPAN >= HISTORY_LENGTH) ? 0 :
		(HISTORY_LENGTH - MEDIAN_SPAN) / 2;
	localparam int MID_LAST  = (MEDIAN_SPAN >= HISTORY_LENGTH) ? HISTORY_LENGTH :
		(HISTORY_LENGTH + MEDIAN_SPAN) / 2;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_LO    = 4'd1;
	localparam logic [3:0] S_MID   = 4'd2;
	localparam logic [3:0] S_NEXT  = 4'd3;
	localparam logic [3:0] S_DIV   = 4'd4;
	localparam logic [3:0] S_HIST  = 4'd5;
	localparam logic [3:0] S_SORT  = 4'd6;
	localparam logic [3:0] S_SUM   = 4'd7;
	localparam logic [3:0] S_MEAN  = 4'd8;
	localparam logic [3:0] S_MWAIT = 4'd9;
	localparam logic [3:0] S_OUT   = 4'd10;

	logic [3:0]              state_q;
	logic [LAGC_W-1:0]       lag_q;
	logic [AW-1:0]           k_q;
	logic signed [ACC_W-1:0] r_prev_q;
	logic signed [ACC_W-1:0] r_mid_q;
	logic [HR_W-1:0]         hr_q;
	logic [HR_W-1:0]         hist_q [HISTORY_LENGTH];
	logic [HR_W-1:0]         sort_n [HISTORY_LENGTH];
	logic [HIW-1:0]          hidx_q;
	logic [HIW-1:0]          pass_q;
	logic [HIW-1:0]          sidx_q;
	logic [NUM_W-1:0]        sum_q;
	logic [CW-1:0]           n_q;
	logic                    corr_start_q;
	logic [AW-1:0]           corr_k_q;
	logic                    div_start_q;
	logic [NUM_W-1:0]        div_num_q;
	logic [LAGC_W-1:0]       div_den_q;
	logic [LAGC_W-1:0]       start_lag;
	logic [AW-1:0]           k0;
	logic [AW-1:0]           km1;
	logic                    out_room;
	logic                    out_push;
	logic                    out_pop;
	result_t                 out_data;
	result_t                 o0_q;
	result_t                 o1_q;
	logic [1:0]              ocnt_q;

	function automatic logic [AW-1:0] lag_mod(input logic [LAGC_W-1:0] v);
		logic [31:0] t;
		t = 32'(v);
		for (int s = 0; s < 8; s++) begin
			if (t >= 32'(WINDOW_LENGTH)) begin
				t = t - 32'(WINDOW_LENGTH);
			end
		end
		return t[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] k_inc(input logic [AW-1:0] k);
		return (k == AW'(WINDOW_LENGTH - 1)) ? '0 : k + AW'(1);
	endfunction

	// first lag searched and its circular neighbor below
	assign start_lag = (cfg.min_lag == '0) ? LAGC_W'(1) : {1'b0, cfg.min_lag};
	assign k0        = lag_mod(start_lag);
	assign km1       = (k0 == '0) ? AW'(WINDOW_LENGTH - 1) : k0 - AW'(1);

	assign corr_start = corr_start_q;
	assign corr_k     = corr_k_q;
	assign div_start  = div_start_q;
	assign div_num    = div_num_q;
	assign div_den    = div_den_q;

	// queue handshakes
	assign out_room = (ocnt_q != 2'd2);
	assign out_pop  = pop & ~empty;
	always_comb begin
		ctl.pop           = (state_q == S_IDLE) && desc.valid && (desc.trig || out_room);
		out_push          = ((state_q == S_IDLE) && desc.valid && !desc.trig && out_room) ||
			((state_q == S_OUT) && out_room);
		ctl.analysis_done = (state_q == S_OUT) && out_room;
		out_data.hr       = hr_q;
		out_data.upd      = (state_q == S_OUT);
	end

	// one odd-even transposition pass over the history
	always_comb begin
		sort_n = hist_q;
		for (int e = 0; e < HISTORY_LENGTH - 1; e++) begin
			if (((e & 1) == int'(pass_q[0])) && (hist_q[e] > hist_q[e+1])) begin
				sort_n[e]   = hist_q[e+1];
				sort_n[e+1] = hist_q[e];
			end
		end
	end

	// analysis sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			lag_q        <= '0;
			k_q          <= '0;
			r_prev_q     <= '0;
			r_mid_q      <= '0;
			hr_q         <= '0;
			hidx_q       <= '0;
			pass_q       <= '0;
			sidx_q       <= '0;
			sum_q        <= '0;
			n_q          <= '0;
			corr_start_q <= 1'b0;
			corr_k_q     <= '0;
			div_start_q  <= 1'b0;
			div_num_q    <= '0;
			div_den_q    <= '0;
			for (int h = 0; h < HISTORY_LENGTH; h++) begin
				hist_q[h] <= '0;
			end
		end else begin
			corr_start_q <= 1'b0;
			div_start_q  <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (desc.valid && desc.trig) begin
						if (start_lag > {1'b0, cfg.max_lag}) begin
							state_q <= S_HIST;
						end else begin
							lag_q        <= start_lag;
							k_q          <= k0;
							corr_start_q <= 1'b1;
							corr_k_q     <= km1;
							state_q      <= S_LO;
						end
					end
				end
				S_LO: begin
					if (corr_done) begin
						r_prev_q     <= corr_result;
						corr_start_q <= 1'b1;
						corr_k_q     <= k_q;
						state_q      <= S_MID;
					end
				end
				S_MID: begin
					if (corr_done) begin
						r_mid_q      <= corr_result;
						corr_start_q <= 1'b1;
						corr_k_q     <= k_inc(k_q);
						state_q      <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (corr_done) begin
						if ((r_mid_q > r_prev_q) && (r_mid_q > corr_result)) begin
							div_start_q <= 1'b1;
							div_num_q   <= NUM_W'(cfg.rate_constant);
							div_den_q   <= lag_q;
							state_q     <= S_DIV;
						end else if (lag_q == {1'b0, cfg.max_lag}) begin
							state_q <= S_HIST;
						end else begin
							lag_q        <= lag_q + LAGC_W'(1);
							k_q          <= k_inc(k_q);
							r_prev_q     <= r_mid_q;
							r_mid_q      <= corr_result;
							corr_start_q <= 1'b1;
							corr_k_q     <= k_inc(k_inc(k_q));
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						hr_q    <= div_quot[HR_W-1:0];
						state_q <= S_HIST;
					end
				end
				S_HIST: begin
					hist_q[hidx_q] <= hr_q;
					hidx_q  <= (hidx_q == HIW'(HISTORY_LENGTH - 1)) ? '0 : hidx_q + HIW'(1);
					pass_q  <= '0;
					state_q <= S_SORT;
				end
				S_SORT: begin
					hist_q <= sort_n;
					pass_q <= pass_q + HIW'(1);
					if (pass_q == HIW'(HISTORY_LENGTH - 1)) begin
						sidx_q  <= HIW'(MID_FIRST);
						sum_q   <= '0;
						n_q     <= '0;
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					if (hist_q[sidx_q] != '0) begin
						sum_q <= sum_q + NUM_W'(hist_q[sidx_q]);
						n_q   <= n_q + CW'(1);
					end
					if (sidx_q == HIW'(MID_LAST - 1)) begin
						state_q <= S_MEAN;
					end else begin
						sidx_q <= sidx_q + HIW'(1);
					end
				end
				S_MEAN: begin
					if (n_q == '0) begin
						state_q <= S_OUT;
					end else begin
						div_start_q <= 1'b1;
						div_num_q   <= sum_q;
						div_den_q   <= LAGC_W'(n_q);
						state_q     <= S_MWAIT;
					end
				end
				S_MWAIT: begin
					if (div_done) begin
						hr_q    <= div_quot[HR_W-1:0];
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_room) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// two-entry result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocnt_q <= 2'd0;
			o0_q   <= '0;
			o1_q   <= '0;
		end else begin
			case ({out_push, out_pop})
				2'b10: begin
					if (ocnt_q == 2'd0) begin
						o0_q <= out_data;
					end else begin
						o1_q <= out_data;
					end
					ocnt_q <= ocnt_q + 2'd1;
				end
				2'b01: begin
					o0_q   <= o1_q;
					ocnt_q <= ocnt_q - 2'd1;
				end
				2'b11: begin
					if (ocnt_q == 2'd1) begin
						o0_q <= out_data;
					end else begin
						o0_q <= o1_q;
						o1_q <= out_data;
					end
				end
				default: ;
			endcase
		end
	end

	assign empty            = (ocnt_q == 2'd0);
	assign heart_rate_x10   = o0_q.hr;
	assign estimate_updated = o0_q.upd;

endmodule

>>> rtl/autocorrelation_heart_rate.sv
// Heart-rate estimator by circular autocorrelation of a PPG sample window.
// Input queue side: push/full with filtered_sample; a transfer happens when
// push is high and full is low. Result queue side: empty/pop; the oldest
// result (heart_rate_x10, estimate_updated) shows while empty is low and is
// taken when pop is high. Configuration: cfg_valid/cfg_ready with cfg_index
// and cfg_data; the user must write them only while the block is idle, which
// the block itself does not enforce; cfg_ready stays high. Every sample gives
// one result. A sample that does not start an analysis passes through the
// internal queue and then the result queue, and such samples are taken one per
// cycle while full is low. A sample that starts an analysis raises full until
// its result is queued: the analysis sweeps the shared multiply-accumulate over
// the dual-read window RAM once for each lag searched and for the lag on each
// side of that range, then runs HISTORY_LENGTH sort passes, the middle-span sum
// and up to two serial divisions. Reset clears configuration to defaults, the
// window (through a fill count), the history and the rate. A stalled receiver
// holds results in a two-entry queue; once it and the internal queue are full,
// full rises.
module autocorrelation_heart_rate #(
	parameter int WINDOW_LENGTH  = achr_pkg::DEF_WINDOW_LENGTH,
	parameter int HISTORY_LENGTH = achr_pkg::DEF_HISTORY_LENGTH,
	parameter int MEDIAN_SPAN    = achr_pkg::DEF_MEDIAN_SPAN
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic signed [achr_pkg::SAMPLE_W-1:0]  filtered_sample,
	output logic                                  empty,
	input  logic                                  pop,
	output logic [achr_pkg::HR_W-1:0]             heart_rate_x10,
	output logic                                  estimate_updated,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [achr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [achr_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import achr_pkg::*;

	localparam int AW    = $clog2(WINDOW_LENGTH);
	localparam int ACC_W = 2 * SAMPLE_W + AW + 1;
	localparam int NUM_W = HR_W + $clog2(HISTORY_LENGTH + 1);

	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [SAMPLE_W-1:0]     ram_wdata;
	logic [AW-1:0]           raddr_a;
	logic [AW-1:0]           raddr_b;
	logic [SAMPLE_W-1:0]     rdata_a;
	logic [SAMPLE_W-1:0]     rdata_b;
	logic [AW:0]             fill;
	cfg_t                    cfg;
	desc_t                   desc;
	back_ctl_t               ctl;
	logic                    corr_start;
	logic [AW-1:0]           corr_k;
	logic                    corr_done;
	logic signed [ACC_W-1:0] corr_result;
	logic                    div_start;
	logic [NUM_W-1:0]        div_num;
	logic [LAGC_W-1:0]       div_den;
	logic                    div_done;
	logic [NUM_W-1:0]        div_quot;

	// sample intake and configuration
	achr_front #(
		.WINDOW_LENGTH(WINDOW_LENGTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.filtered_sample(filtered_sample),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.ram_we(ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.fill(fill),
		.cfg(cfg),
		.desc(desc),
		.ctl(ctl)
	);

	// sample window
	achr_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(WINDOW_LENGTH)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	// autocorrelation unit
	achr_corr #(
		.WINDOW_LENGTH(WINDOW_LENGTH)
	) u_corr (
		.clk(clk),
		.arst_n(arst_n),
		.start(corr_start),
		.lag_idx(corr_k),
		.fill(fill),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b),
		.done(corr_done),
		.result(corr_result)
	);

	// shared divider for rate and mean
	achr_div #(
		.NUM_W(NUM_W),
		.DEN_W(LAGC_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(div_den),
		.done(div_done),
		.quot(div_quot)
	);

	// peak search, history and result queue
	achr_back #(
		.WINDOW_LENGTH(WINDOW_LENGTH),
		.HISTORY_LENGTH(HISTORY_LENGTH),
		.MEDIAN_SPAN(MEDIAN_SPAN)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.desc(desc),
		.ctl(ctl),
		.corr_start(corr_start),
		.corr_k(corr_k),
		.corr_done(corr_done),
		.corr_result(corr_result),
		.div_start(div_start),
		.div_num(div_num),
		.div_den(div_den),
		.div_done(div_done),
		.div_quot(div_quot),
		.empty(empty),
		.pop(pop),
		.heart_rate_x10(heart_rate_x10),
		.estimate_updated(estimate_updated)
	);

endmodule

>>> rtl/achr_chk.sv
// achr_chk: port-level checks for autocorrelation_heart_rate, bound to it.
// Depends on achr_pkg.
module achr_chk (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 empty,
	input logic                                 pop,
	input logic [achr_pkg::HR_W-1:0]            heart_rate_x10,
	input logic                                 estimate_updated
);
	import achr_pkg::*;

	logic [HR_W-1:0] hr_last_q;

	// rate of the last result transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hr_last_q <= '0;
		end else if (pop && !empty) begin
			hr_last_q <= heart_rate_x10;
		end
	end

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(heart_rate_x10) && $stable(estimate_updated))
		else $error("result changed while stalled");

	// the rate only changes with an analysis
	a_rate_keep: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !estimate_updated |-> heart_rate_x10 == hr_last_q)
		else $error("rate changed without an analysis");

	// no result while reset stays asserted
	a_reset_empty: assert property (@(posedge clk) !arst_n ##1 !arst_n |-> empty)
		else $error("result shown during reset");

endmodule

bind autocorrelation_heart_rate achr_chk u_achr_chk (.*);
